>>> rtl/bfte_pkg.sv
// Shared types, codes and helpers of the face triangle expander.
package bfte_pkg;

  // Request codes carried in req_type.
  localparam logic REQ_WRITE = 1'b0;
  localparam logic REQ_FACE  = 1'b1;

  // Face kinds that are expanded.
  localparam logic signed [31:0] KIND_POLYGON = 32'sd1;
  localparam logic signed [31:0] KIND_MESH    = 32'sd3;

  // Result kinds.
  localparam logic OUT_TRIANGLE = 1'b0;
  localparam logic OUT_EMPTY    = 1'b1;

  // Configuration register indexes.
  localparam logic [0:0] REG_VERTEX_LIMIT = 1'b0;
  localparam logic [0:0] REG_TABLE_USED   = 1'b1;

  localparam logic [15:0] VERTEX_LIMIT_RST = 16'd1;
  localparam logic [12:0] TABLE_USED_RST   = 13'd0;

  // Triangle counts of one face fit in seven bits (cap is at most 64).
  localparam int TRI_W = 7;

  // Division of a value below 256 by three: (x * 171) >> 9.
  localparam int RECIP3       = 171;
  localparam int RECIP3_SHIFT = 9;

  // Depth of the command queue between front and back.
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = 1;
  localparam int QCNT_W      = 2;

  typedef struct packed {
    logic               req_type;
    logic [11:0]        entry_slot;
    logic signed [31:0] entry_offset;
    logic signed [31:0] face_kind;
    logic signed [31:0] base_vertex;
    logic signed [31:0] first_entry;
    logic signed [31:0] entry_total;
  } in_t;

  typedef struct packed {
    logic        out_kind;
    logic [15:0] corner_a;
    logic [15:0] corner_b;
    logic [15:0] corner_c;
    logic [31:0] built_count;
    logic [31:0] skipped_count;
    logic        truncated;
    logic        last;
  } out_t;

  // Classified command passed from the front to the back.
  typedef struct packed {
    logic               is_write;
    logic [11:0]        entry_slot;
    logic signed [31:0] entry_offset;
    logic signed [31:0] base_vertex;
    logic signed [31:0] first_entry;
    logic [TRI_W-1:0]   tris;
    logic               trunc;
  } cmd_t;

  // Configuration as seen by the back.
  typedef struct packed {
    logic [15:0] vertex_limit;
    logic [12:0] table_used;
  } cfg_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CHECK,
    ST_READ,
    ST_FETCH,
    ST_LOAD
  } back_state_e;

  function automatic logic [31:0] sat_inc(input logic [31:0] v);
    return (v == 32'hFFFF_FFFF) ? v : v + 32'd1;
  endfunction

endpackage

>>> rtl/bfte_ram.sv
// Generic single-write, single-read RAM with registered read data.
module bfte_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                                   clk_i,
  input  logic                                   we_i,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                       wdata_i,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                       rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

>>> rtl/bfte_front.sv
// Front end: accepts input items, drops those without effect and classifies the rest.
module bfte_front #(
  parameter int TABLE_DEPTH       = 4096,
  parameter int FACE_TRIANGLE_CAP = 64
) (
  input  logic           in_valid_i,
  output logic           in_ready_o,
  input  bfte_pkg::in_t  in_item_i,
  input  logic           q_full_i,
  output logic           push_o,
  output bfte_pkg::cmd_t cmd_o
);

  // A face with at least this many offsets has more triangles than the cap.
  localparam int TruncAt = 3 * (FACE_TRIANGLE_CAP + 1);

  logic        slot_ok;
  logic        face_ok;
  logic        keep;
  logic        trunc;
  logic [16:0] prod;

  always_comb begin
    slot_ok = int'(in_item_i.entry_slot) < TABLE_DEPTH;
    face_ok = ((in_item_i.face_kind == bfte_pkg::KIND_POLYGON) ||
               (in_item_i.face_kind == bfte_pkg::KIND_MESH)) &&
              (in_item_i.entry_total >= 32'sd3);
    keep = (in_item_i.req_type == bfte_pkg::REQ_WRITE) ? slot_ok : face_ok;
    trunc = in_item_i.entry_total >= 32'(TruncAt);
    // Below the truncation point the total is under 256, so three divides it
    // through a reciprocal multiply.
    prod = 17'(in_item_i.entry_total[7:0]) * 17'(bfte_pkg::RECIP3);

    cmd_o.is_write     = (in_item_i.req_type == bfte_pkg::REQ_WRITE);
    cmd_o.entry_slot   = in_item_i.entry_slot;
    cmd_o.entry_offset = in_item_i.entry_offset;
    cmd_o.base_vertex  = in_item_i.base_vertex;
    cmd_o.first_entry  = in_item_i.first_entry;
    cmd_o.trunc        = trunc;
    cmd_o.tris         = trunc ? bfte_pkg::TRI_W'(FACE_TRIANGLE_CAP)
                               : prod[bfte_pkg::RECIP3_SHIFT +: bfte_pkg::TRI_W];
  end

  assign in_ready_o = !q_full_i;
  assign push_o     = in_valid_i && !q_full_i && keep;

endmodule

>>> rtl/bfte_queue.sv
// Short command queue between the front and the back.
module bfte_queue (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  bfte_pkg::cmd_t cmd_i,
  output logic           full_o,
  output logic           valid_o,
  output bfte_pkg::cmd_t cmd_o,
  input  logic           pop_i
);

  bfte_pkg::cmd_t                   entry_q [bfte_pkg::QUEUE_DEPTH];
  logic [bfte_pkg::QPTR_W-1:0]      wr_ptr_q, wr_ptr_d;
  logic [bfte_pkg::QPTR_W-1:0]      rd_ptr_q, rd_ptr_d;
  logic [bfte_pkg::QCNT_W-1:0]      cnt_q, cnt_d;
  logic                             do_push, do_pop;

  assign full_o  = (cnt_q == bfte_pkg::QCNT_W'(bfte_pkg::QUEUE_DEPTH));
  assign valid_o = (cnt_q != '0);
  assign cmd_o   = entry_q[rd_ptr_q];

  always_comb begin
    do_push  = push_i && !full_o;
    do_pop   = pop_i && valid_o;
    wr_ptr_d = do_push ? wr_ptr_q + 1'b1 : wr_ptr_q;
    rd_ptr_d = do_pop ? rd_ptr_q + 1'b1 : rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      entry_q[wr_ptr_q] <= cmd_i;
    end
  end

endmodule

>>> rtl/bfte_back.sv
// Back end: table writes, triangle checks, result buffering and emission.
module bfte_back #(
  parameter int TABLE_DEPTH       = 4096,
  parameter int FACE_TRIANGLE_CAP = 64
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           cmd_valid_i,
  input  bfte_pkg::cmd_t cmd_i,
  output logic           cmd_pop_o,
  input  bfte_pkg::cfg_t cfg_i,
  output logic           out_valid_o,
  input  logic           out_ready_i,
  output bfte_pkg::out_t out_item_o
);

  localparam int TblAw = $clog2(TABLE_DEPTH);
  localparam int BufAw = (FACE_TRIANGLE_CAP > 1) ? $clog2(FACE_TRIANGLE_CAP) : 1;

  bfte_pkg::back_state_e       state_q, state_d;
  bfte_pkg::cmd_t              face_q;
  logic [bfte_pkg::TRI_W-1:0]  tri_q, cnt_q, emit_q;
  logic signed [33:0]          pos_q;
  logic [1:0]                  corner_q;
  logic                        ok_q;
  logic [15:0]                 ca_q, cb_q;
  logic [31:0]                 built_q, skipped_q;
  logic                        out_valid_q;
  bfte_pkg::out_t              out_q;

  logic signed [33:0]          used_s, depth_s, lim_tbl, lim_vtx, idx;
  logic                        bound_bad, idx_good, tri_good, tris_done;
  logic                        res_last, out_load, face_pop;

  logic                        tbl_we;
  logic [TblAw-1:0]            tbl_waddr, tbl_raddr;
  logic [31:0]                 tbl_rdata;
  logic                        buf_we;
  logic [BufAw-1:0]            buf_waddr, buf_raddr;
  logic [47:0]                 buf_wdata, buf_rdata;

  // Checks on the current triangle and the current result.
  always_comb begin
    used_s    = 34'(cfg_i.table_used);
    depth_s   = 34'(TABLE_DEPTH);
    lim_tbl   = (used_s > depth_s) ? depth_s : used_s;
    lim_vtx   = 34'(cfg_i.vertex_limit);
    bound_bad = (pos_q < 34'sd0) || ((pos_q + 34'sd2) >= lim_tbl);
    idx       = 34'($signed(face_q.base_vertex)) + 34'($signed(tbl_rdata));
    idx_good  = (idx >= 34'sd0) && (idx < lim_vtx);
    tri_good  = ok_q && idx_good;
    tris_done = (tri_q == face_q.tris);
    res_last  = (cnt_q == '0) || (emit_q == cnt_q - 1'b1);
    out_load  = (state_q == bfte_pkg::ST_LOAD) && (!out_valid_q || out_ready_i);
    face_pop  = (state_q == bfte_pkg::ST_IDLE) && cmd_valid_i && !cmd_i.is_write;
  end

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      bfte_pkg::ST_IDLE: begin
        if (face_pop) begin
          state_d = bfte_pkg::ST_CHECK;
        end
      end
      bfte_pkg::ST_CHECK: begin
        if (tris_done) begin
          state_d = bfte_pkg::ST_FETCH;
        end else if (!bound_bad) begin
          state_d = bfte_pkg::ST_READ;
        end
      end
      bfte_pkg::ST_READ: begin
        if (corner_q == 2'd3) begin
          state_d = bfte_pkg::ST_CHECK;
        end
      end
      bfte_pkg::ST_FETCH: begin
        state_d = bfte_pkg::ST_LOAD;
      end
      bfte_pkg::ST_LOAD: begin
        if (out_load) begin
          state_d = res_last ? bfte_pkg::ST_IDLE : bfte_pkg::ST_FETCH;
        end
      end
      default: begin
        state_d = bfte_pkg::ST_IDLE;
      end
    endcase
  end

  // Memory and queue controls.
  always_comb begin
    cmd_pop_o = (state_q == bfte_pkg::ST_IDLE) && cmd_valid_i;
    tbl_we    = cmd_pop_o && cmd_i.is_write;
    tbl_waddr = TblAw'(cmd_i.entry_slot);
    tbl_raddr = TblAw'(pos_q + 34'(corner_q));
    buf_we    = (state_q == bfte_pkg::ST_READ) && (corner_q == 2'd3) && tri_good;
    buf_waddr = cnt_q[BufAw-1:0];
    buf_wdata = {ca_q, cb_q, idx[15:0]};
    buf_raddr = emit_q[BufAw-1:0];
  end

  bfte_ram #(
    .WIDTH (32),
    .DEPTH (TABLE_DEPTH)
  ) u_table (
    .clk_i   (clk_i),
    .we_i    (tbl_we),
    .waddr_i (tbl_waddr),
    .wdata_i (cmd_i.entry_offset),
    .raddr_i (tbl_raddr),
    .rdata_o (tbl_rdata)
  );

  bfte_ram #(
    .WIDTH (48),
    .DEPTH (FACE_TRIANGLE_CAP)
  ) u_result_buf (
    .clk_i   (clk_i),
    .we_i    (buf_we),
    .waddr_i (buf_waddr),
    .wdata_i (buf_wdata),
    .raddr_i (buf_raddr),
    .rdata_o (buf_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= bfte_pkg::ST_IDLE;
      out_valid_q <= 1'b0;
      built_q     <= '0;
      skipped_q   <= '0;
      tri_q       <= '0;
      cnt_q       <= '0;
      emit_q      <= '0;
      corner_q    <= '0;
    end else begin
      state_q <= state_d;
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        bfte_pkg::ST_IDLE: begin
          if (face_pop) begin
            tri_q <= '0;
            cnt_q <= '0;
          end
        end
        bfte_pkg::ST_CHECK: begin
          if (tris_done) begin
            emit_q <= '0;
          end else if (bound_bad) begin
            skipped_q <= bfte_pkg::sat_inc(skipped_q);
            tri_q     <= tri_q + 1'b1;
          end else begin
            corner_q <= '0;
          end
        end
        bfte_pkg::ST_READ: begin
          if (corner_q == 2'd3) begin
            tri_q <= tri_q + 1'b1;
            if (tri_good) begin
              built_q <= bfte_pkg::sat_inc(built_q);
              cnt_q   <= cnt_q + 1'b1;
            end else begin
              skipped_q <= bfte_pkg::sat_inc(skipped_q);
            end
          end else begin
            corner_q <= corner_q + 1'b1;
          end
        end
        bfte_pkg::ST_FETCH: begin
        end
        bfte_pkg::ST_LOAD: begin
          if (out_load && !res_last) begin
            emit_q <= emit_q + 1'b1;
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (face_pop) begin
      face_q <= cmd_i;
      pos_q  <= 34'($signed(cmd_i.first_entry));
    end
    if (state_q == bfte_pkg::ST_CHECK && !tris_done) begin
      if (bound_bad) begin
        pos_q <= pos_q + 34'sd3;
      end else begin
        ok_q <= 1'b1;
      end
    end
    if (state_q == bfte_pkg::ST_READ) begin
      // Read data of corner k arrives while corner_q is k + 1.
      if (corner_q == 2'd1) begin
        ca_q <= idx[15:0];
      end
      if (corner_q == 2'd2) begin
        cb_q <= idx[15:0];
      end
      if (corner_q != 2'd0) begin
        ok_q <= ok_q && idx_good;
      end
      if (corner_q == 2'd3) begin
        pos_q <= pos_q + 34'sd3;
      end
    end
    if (out_load) begin
      out_q.out_kind      <= (cnt_q == '0) ? bfte_pkg::OUT_EMPTY : bfte_pkg::OUT_TRIANGLE;
      out_q.corner_a      <= (cnt_q == '0) ? 16'd0 : buf_rdata[47:32];
      out_q.corner_b      <= (cnt_q == '0) ? 16'd0 : buf_rdata[31:16];
      out_q.corner_c      <= (cnt_q == '0) ? 16'd0 : buf_rdata[15:0];
      out_q.built_count   <= built_q;
      out_q.skipped_count <= skipped_q;
      out_q.truncated     <= face_q.trunc;
      out_q.last          <= res_last;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

endmodule

>>> rtl/bsp_face_triangle_expander.sv
// Top level of the face triangle expander: configuration registers, front, queue and back.
//
//   Channel   Signals                              Moves
//   --------  -----------------------------------  --------------------------------------
//   input     in_valid_i / in_ready_o / in_item_i  one table write or one face request
//   output    out_valid_o / out_ready_i / out_item_o  one triangle or one empty-face marker
//   config    cfg_we_i / cfg_idx_i / cfg_wdata_i   one register write, no handshake
//
// The front takes an item in any cycle in which the two-entry command queue has room;
// items without effect are dropped there. The back executes one command at a time; a
// table write is done as it leaves the queue. A face is captured from the queue, then
// each triangle gets a table-bound check and, when the check passes, three reads of
// the offset table through its one read port and the final index check; each result
// is then fetched from the result buffer and loaded into the output register. Results
// of a face leave only after all its triangles are examined, because each carries the
// final totals. Reset clears control state and the totals; the offset table needs no
// clearing. A stalled output holds its item while the queue keeps filling.
module bsp_face_triangle_expander #(
  parameter int TABLE_DEPTH       = 4096,
  parameter int FACE_TRIANGLE_CAP = 64
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  input  bfte_pkg::in_t  in_item_i,
  output logic           out_valid_o,
  input  logic           out_ready_i,
  output bfte_pkg::out_t out_item_o,
  input  logic           cfg_we_i,
  input  logic [0:0]     cfg_idx_i,
  input  logic [15:0]    cfg_wdata_i
);

  bfte_pkg::cfg_t cfg_q;
  bfte_pkg::cmd_t front_cmd, queue_cmd;
  logic           push, q_full, q_valid, q_pop;

  // Configuration registers. The user must write them only while the block is idle.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.vertex_limit <= bfte_pkg::VERTEX_LIMIT_RST;
      cfg_q.table_used   <= bfte_pkg::TABLE_USED_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        bfte_pkg::REG_VERTEX_LIMIT: cfg_q.vertex_limit <= cfg_wdata_i;
        bfte_pkg::REG_TABLE_USED:   cfg_q.table_used   <= cfg_wdata_i[12:0];
        default: begin
        end
      endcase
    end
  end

  // The front classifies every item in the cycle it is accepted.
  bfte_front #(
    .TABLE_DEPTH       (TABLE_DEPTH),
    .FACE_TRIANGLE_CAP (FACE_TRIANGLE_CAP)
  ) u_front (
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_item_i  (in_item_i),
    .q_full_i   (q_full),
    .push_o     (push),
    .cmd_o      (front_cmd)
  );

  // Table writes and faces stay in order through the queue, so a write never
  // overtakes a face that was submitted before it.
  bfte_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .cmd_i   (front_cmd),
    .full_o  (q_full),
    .valid_o (q_valid),
    .cmd_o   (queue_cmd),
    .pop_i   (q_pop)
  );

  // The back owns the offset table, the result buffer, the totals and the output register.
  bfte_back #(
    .TABLE_DEPTH       (TABLE_DEPTH),
    .FACE_TRIANGLE_CAP (FACE_TRIANGLE_CAP)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_valid_i (q_valid),
    .cmd_i       (queue_cmd),
    .cmd_pop_o   (q_pop),
    .cfg_i       (cfg_q),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_item_o  (out_item_o)
  );

endmodule

>>> rtl/bfte_checker.sv
// Port-level assertions for the face triangle expander, bound to the top level.
module bfte_checker (
  input logic           clk_i,
  input logic           rst_ni,
  input logic           out_valid_i,
  input logic           out_ready_i,
  input bfte_pkg::out_t out_item_i
);

  logic        acc;
  logic        mid_q;
  logic        seen_q;
  logic [31:0] built_prev_q, skipped_prev_q;

  assign acc = out_valid_i && out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mid_q          <= 1'b0;
      seen_q         <= 1'b0;
      built_prev_q   <= '0;
      skipped_prev_q <= '0;
    end else if (acc) begin
      mid_q          <= !out_item_i.last;
      seen_q         <= 1'b1;
      built_prev_q   <= out_item_i.built_count;
      skipped_prev_q <= out_item_i.skipped_count;
    end
  end

  // A waiting item stays put.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(out_item_i))
    else $error("output item changed while stalled");

  // An empty-face marker is the only result of its face and has no corners.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && (out_item_i.out_kind == bfte_pkg::OUT_EMPTY) |->
      out_item_i.last && (out_item_i.corner_a == 16'd0) &&
      (out_item_i.corner_b == 16'd0) && (out_item_i.corner_c == 16'd0))
    else $error("empty-face result malformed");

  // All results of one face carry the same totals.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    acc && mid_q |-> (out_item_i.built_count == built_prev_q) &&
                     (out_item_i.skipped_count == skipped_prev_q))
    else $error("totals changed within a face");

  // Totals never go down.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    acc && seen_q |-> (out_item_i.built_count >= built_prev_q) &&
                      (out_item_i.skipped_count >= skipped_prev_q))
    else $error("totals decreased");

endmodule

bind bsp_face_triangle_expander bfte_checker u_bfte_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .out_valid_i (out_valid_o),
  .out_ready_i (out_ready_i),
  .out_item_i  (out_item_o)
);
